// ----- rtl/sha1md_pkg.sv -----
// Shared types, constants and widths of the SHA-1 digest block.
package sha1md_pkg;

   localparam int unsigned WORD_W      = 32;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned INDEX_W     = 3;
   localparam int unsigned LEN_W       = 64;
   localparam int unsigned ROUND_W     = 7;
   localparam int unsigned FILL_W      = 6;
   localparam int unsigned LEN_IDX_W   = 4;
   localparam int unsigned BLOCK_WORDS = 16;
   localparam int unsigned WIN_W       = BLOCK_WORDS * WORD_W;

   typedef logic [WORD_W-1:0] word_type;

   // Five working or chaining words.
   typedef struct packed {
      word_type a;
      word_type b;
      word_type c;
      word_type d;
      word_type e;
   } round_state_type;

   // Taps of the message schedule window; w0 is the word used this round.
   typedef struct packed {
      word_type w0;
      word_type w2;
      word_type w8;
      word_type w13;
   } sched_taps_type;

   // Round limits and counts.
   localparam logic [ROUND_W-1:0]   LAST_ROUND  = 7'd79;
   localparam logic [ROUND_W-1:0]   ROUND_END_1 = 7'd20;
   localparam logic [ROUND_W-1:0]   ROUND_END_2 = 7'd40;
   localparam logic [ROUND_W-1:0]   ROUND_END_3 = 7'd60;
   localparam logic [FILL_W-1:0]    FILL_LAST   = 6'd63;
   localparam logic [FILL_W-1:0]    LEN_POS     = 6'd56;
   localparam logic [LEN_IDX_W-1:0] LEN_BYTES   = 4'd8;
   localparam logic [INDEX_W-1:0]   LAST_INDEX  = 3'd4;
   localparam logic [BYTE_W-1:0]    PAD_MARK    = 8'h80;
   localparam logic [BYTE_W-1:0]    PAD_ZERO    = 8'h00;
   localparam logic [LEN_W-1:0]     BITS_PER_BYTE = 64'd8;

   // Round constants.
   localparam word_type K_0 = 32'h5a827999;
   localparam word_type K_1 = 32'h6ed9eba1;
   localparam word_type K_2 = 32'h8f1bbcdc;
   localparam word_type K_3 = 32'hca62c1d6;

   // Initial chaining values.
   localparam round_state_type INIT_CHAIN = '{
      a: 32'h67452301,
      b: 32'hefcdab89,
      c: 32'h98badcfe,
      d: 32'h10325476,
      e: 32'hc3d2e1f0
   };

endpackage

// ----- rtl/sha1md_if.sv -----
// Handshake interfaces for the message byte channel and the digest word channel.
interface sha1md_req_if;
   logic                             valid;
   logic                             ready;
   logic [sha1md_pkg::BYTE_W-1:0]    data_byte;
   logic                             byte_present;
   logic                             end_of_message;

   modport source (output valid, output data_byte, output byte_present,
                   output end_of_message, input ready);
   modport sink (input valid, input data_byte, input byte_present,
                 input end_of_message, output ready);
endinterface

interface sha1md_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [sha1md_pkg::WORD_W-1:0]    digest_word;
   logic [sha1md_pkg::INDEX_W-1:0]   word_index;
   logic                             last_word;

   modport source (output valid, output digest_word, output word_index,
                   output last_word, input ready);
   modport sink (input valid, input digest_word, input word_index,
                 input last_word, output ready);
endinterface

// ----- rtl/sha1_message_digest.sv -----
// Top level of the SHA-1 digest block: byte window, padding sequencer and digest output.
//
//   channel    direction   handshake       payload
//   req_chan   in          valid / ready   data_byte[7:0], byte_present, end_of_message
//   rsp_chan   out         valid / ready   digest_word[31:0], word_index[2:0], last_word
//
// A word carrying a byte is taken whenever the block is idle. The 64th byte of a block starts the
// compression: the 80 rounds on the shared round unit, then the chaining add; no byte is taken
// meanwhile. An end of message appends 9 to 72 padding bytes plus one compression per
// padded block, then sends the five digest words.
// Reset is synchronous and restores the initial chaining values; req_chan.ready is low
// from the end of message until the last digest word is taken, and a stalled rsp_chan
// simply holds the current digest word.
module sha1_message_digest (
   input  logic              clock,
   input  logic              reset,
   sha1md_req_if.sink        req_chan,
   sha1md_rsp_if.source      rsp_chan
);
   import sha1md_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FINISH,
      ST_PAD,
      ST_EMIT
   } state_type;

   state_type              state_ff,      state_in;
   round_state_type        chain_ff,      chain_in;
   round_state_type        work_ff,       work_in;
   logic [WIN_W-1:0]       window_ff,     window_in;
   logic [FILL_W-1:0]      fill_ff,       fill_in;
   logic [LEN_W-1:0]       bits_ff,       bits_in;
   logic [ROUND_W-1:0]     round_ff,      round_in;
   logic [INDEX_W-1:0]     out_idx_ff,    out_idx_in;
   logic [LEN_IDX_W-1:0]   len_idx_ff,    len_idx_in;
   logic                   padding_ff,    padding_in;
   logic                   mark_ff,       mark_in;

   logic                   ins_valid;
   logic [BYTE_W-1:0]      ins_byte;
   logic                   block_full;
   sched_taps_type         taps;
   round_state_type        round_nxt;
   word_type               w_next;

   // Schedule taps at fixed places of the window; the oldest word sits at the top.
   assign taps.w0  = window_ff[WIN_W-1 -: WORD_W];
   assign taps.w2  = window_ff[WIN_W-1-WORD_W*2 -: WORD_W];
   assign taps.w8  = window_ff[WIN_W-1-WORD_W*8 -: WORD_W];
   assign taps.w13 = window_ff[WIN_W-1-WORD_W*13 -: WORD_W];

   sha1md_round u_round (
      .round_idx (round_ff),
      .cur       (work_ff),
      .taps      (taps),
      .nxt       (round_nxt),
      .w_next    (w_next)
   );

   assign block_full = ins_valid && (fill_ff == FILL_LAST);

   // Sequencer: byte intake, padding, rounds, chaining add and digest output.
   always_comb begin
      state_in   = state_ff;
      chain_in   = chain_ff;
      work_in    = work_ff;
      window_in  = window_ff;
      fill_in    = fill_ff;
      bits_in    = bits_ff;
      round_in   = round_ff;
      out_idx_in = out_idx_ff;
      len_idx_in = len_idx_ff;
      padding_in = padding_ff;
      mark_in    = mark_ff;
      ins_valid  = 1'b0;
      ins_byte   = PAD_ZERO;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               if (req_chan.byte_present) begin
                  ins_valid = 1'b1;
                  ins_byte  = req_chan.data_byte;
                  bits_in   = bits_ff + BITS_PER_BYTE;
               end
               if (req_chan.end_of_message) begin
                  padding_in = 1'b1;
                  mark_in    = 1'b1;
                  len_idx_in = '0;
                  state_in   = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            // Marker byte first, zeros up to the length field, then the bit count.
            ins_valid = 1'b1;
            if (mark_ff) begin
               ins_byte = PAD_MARK;
               mark_in  = 1'b0;
            end else if ((len_idx_ff == '0) && (fill_ff != LEN_POS)) begin
               ins_byte = PAD_ZERO;
            end else begin
               ins_byte   = bits_ff[LEN_W-1 -: BYTE_W];
               bits_in    = {bits_ff[LEN_W-BYTE_W-1:0], PAD_ZERO};
               len_idx_in = len_idx_ff + 1'b1;
            end
         end
         ST_ROUND: begin
            work_in   = round_nxt;
            window_in = {window_ff[WIN_W-WORD_W-1:0], w_next};
            round_in  = round_ff + 1'b1;
            if (round_ff == LAST_ROUND) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            chain_in.a = chain_ff.a + work_ff.a;
            chain_in.b = chain_ff.b + work_ff.b;
            chain_in.c = chain_ff.c + work_ff.c;
            chain_in.d = chain_ff.d + work_ff.d;
            chain_in.e = chain_ff.e + work_ff.e;
            if (padding_ff && (len_idx_ff == LEN_BYTES)) begin
               out_idx_in = '0;
               state_in   = ST_EMIT;
            end else if (padding_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (rsp_chan.ready) begin
               if (out_idx_ff == LAST_INDEX) begin
                  chain_in   = INIT_CHAIN;
                  bits_in    = '0;
                  fill_in    = '0;
                  padding_in = 1'b0;
                  mark_in    = 1'b0;
                  len_idx_in = '0;
                  state_in   = ST_IDLE;
               end else begin
                  out_idx_in = out_idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Byte intake into the window; a full block starts the rounds.
      if (ins_valid) begin
         window_in = {window_ff[WIN_W-BYTE_W-1:0], ins_byte};
         if (block_full) begin
            fill_in  = '0;
            work_in  = chain_ff;
            round_in = '0;
            state_in = ST_ROUND;
         end else begin
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   // State and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         chain_ff   <= INIT_CHAIN;
         fill_ff    <= '0;
         bits_ff    <= '0;
         round_ff   <= '0;
         out_idx_ff <= '0;
         len_idx_ff <= '0;
         padding_ff <= 1'b0;
         mark_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         chain_ff   <= chain_in;
         fill_ff    <= fill_in;
         bits_ff    <= bits_in;
         round_ff   <= round_in;
         out_idx_ff <= out_idx_in;
         len_idx_ff <= len_idx_in;
         padding_ff <= padding_in;
         mark_ff    <= mark_in;
      end
   end

   // Payload registers: byte and schedule window, working words.
   always_ff @(posedge clock) begin
      window_ff <= window_in;
      work_ff   <= work_in;
   end

   // Handshakes and digest word selection.
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = (state_ff == ST_EMIT);
   assign rsp_chan.word_index = out_idx_ff;
   assign rsp_chan.last_word  = (out_idx_ff == LAST_INDEX);

   always_comb begin
      case (out_idx_ff)
         3'd0:    rsp_chan.digest_word = chain_ff.a;
         3'd1:    rsp_chan.digest_word = chain_ff.b;
         3'd2:    rsp_chan.digest_word = chain_ff.c;
         3'd3:    rsp_chan.digest_word = chain_ff.d;
         default: rsp_chan.digest_word = chain_ff.e;
      endcase
   end

   // The block never takes a byte while a digest word is on offer.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("input ready while digest output is valid");

   // Rounds always start on an empty buffer.
   a_round_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> (fill_ff == '0))
      else $error("buffer not empty during compression");

   // The digest goes out only after all eight length bytes.
   a_emit_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.word_index == '0)) |-> (len_idx_ff == LEN_BYTES))
      else $error("digest emitted before padding completed");

   // After the last digest word the block takes a fresh message.
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && rsp_chan.last_word) |=>
      (req_chan.ready && (chain_ff == INIT_CHAIN)))
      else $error("block not restarted after digest");

endmodule

// ----- rtl/sha1md_round.sv -----
// One SHA-1 round and one message schedule step, shared by all 80 rounds.
module sha1md_round (
   input  logic [sha1md_pkg::ROUND_W-1:0] round_idx,
   input  sha1md_pkg::round_state_type    cur,
   input  sha1md_pkg::sched_taps_type     taps,
   output sha1md_pkg::round_state_type    nxt,
   output sha1md_pkg::word_type           w_next
);
   import sha1md_pkg::*;

   word_type f_val;
   word_type k_val;
   word_type t_val;
   word_type mix;

   // Round function and constant by round group.
   always_comb begin
      if (round_idx < ROUND_END_1) begin
         f_val = (cur.b & cur.c) | (~cur.b & cur.d);
         k_val = K_0;
      end else if (round_idx < ROUND_END_2) begin
         f_val = cur.b ^ cur.c ^ cur.d;
         k_val = K_1;
      end else if (round_idx < ROUND_END_3) begin
         f_val = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
         k_val = K_2;
      end else begin
         f_val = cur.b ^ cur.c ^ cur.d;
         k_val = K_3;
      end
   end

   // New working words.
   assign t_val = {cur.a[WORD_W-6:0], cur.a[WORD_W-1:WORD_W-5]} + f_val + cur.e + k_val
                  + taps.w0;

   assign nxt.a = t_val;
   assign nxt.b = cur.a;
   assign nxt.c = {cur.b[1:0], cur.b[WORD_W-1:2]};
   assign nxt.d = cur.c;
   assign nxt.e = cur.d;

   // Schedule word sixteen positions ahead of the current one.
   assign mix    = taps.w13 ^ taps.w8 ^ taps.w2 ^ taps.w0;
   assign w_next = {mix[WORD_W-2:0], mix[WORD_W-1]};

endmodule

// ----- dv/sha1_message_digest_tb.sv -----
// Self-checking testbench for the SHA-1 digest block with a predicting scoreboard.
`timescale 1ns / 100ps

module sha1_message_digest_tb;
   import sha1md_pkg::*;

   localparam int unsigned ITEM_TARGET  = 480;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned DRAIN_CYCLES = 200;
   localparam int unsigned LONG_HOLD    = 400;
   localparam int unsigned HOLD_AT_WORD = 7;
   localparam int unsigned MAX_IDLE     = 8;
   localparam int unsigned MAX_REPORTS  = 40;

   // One expected digest word as it should appear on the result channel.
   typedef struct packed {
      word_type             digest_word;
      logic [INDEX_W-1:0]   word_index;
      logic                 last_word;
   } digest_entry_type;

   // Scoreboard: runs its own SHA-1 over the accepted words and holds the digest words due.
   class sha1_digest_scoreboard;
      word_type               chain[5];
      logic [BYTE_W-1:0]      block_bytes[64];
      int unsigned            fill;
      logic [LEN_W-1:0]       bit_len;
      digest_entry_type       expected_digest_words[$];
      int unsigned            errors;

      function new();
         errors = 0;
         restart();
      endfunction

      // Back to the initial chaining values for a fresh message.
      function void restart();
         chain[0] = INIT_CHAIN.a;
         chain[1] = INIT_CHAIN.b;
         chain[2] = INIT_CHAIN.c;
         chain[3] = INIT_CHAIN.d;
         chain[4] = INIT_CHAIN.e;
         fill     = 0;
         bit_len  = '0;
      endfunction

      function word_type rotl(word_type x, int unsigned s);
         return (x << s) | (x >> (WORD_W - s));
      endfunction

      // The 80-round compression of the buffered block into the chaining words.
      function void compress_block();
         word_type sched[80];
         word_type a, b, c, d, e, f, k, t;
         for (int r = 0; r < 16; r++) begin
            sched[r] = {block_bytes[4*r], block_bytes[4*r+1],
                        block_bytes[4*r+2], block_bytes[4*r+3]};
         end
         for (int r = 16; r < 80; r++) begin
            sched[r] = rotl(sched[r-3] ^ sched[r-8] ^ sched[r-14] ^ sched[r-16], 1);
         end
         a = chain[0];
         b = chain[1];
         c = chain[2];
         d = chain[3];
         e = chain[4];
         for (int r = 0; r < 80; r++) begin
            if (r < ROUND_END_1) begin
               f = (b & c) | (~b & d);
               k = K_0;
            end else if (r < ROUND_END_2) begin
               f = b ^ c ^ d;
               k = K_1;
            end else if (r < ROUND_END_3) begin
               f = (b & c) | (b & d) | (c & d);
               k = K_2;
            end else begin
               f = b ^ c ^ d;
               k = K_3;
            end
            t = rotl(a, 5) + f + e + k + sched[r];
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
         end
         chain[0] += a;
         chain[1] += b;
         chain[2] += c;
         chain[3] += d;
         chain[4] += e;
      endfunction

      function void append_byte(logic [BYTE_W-1:0] v);
         block_bytes[fill] = v;
         fill++;
         if (fill == 64) begin
            compress_block();
            fill = 0;
         end
      endfunction

      // Takes one accepted input word; an end of message pads and queues five digest words.
      function void absorb_word(logic [BYTE_W-1:0] data, logic present, logic eom);
         logic [LEN_W-1:0]  len;
         digest_entry_type  entry;
         if (present) begin
            bit_len += BITS_PER_BYTE;
            append_byte(data);
         end
         if (!eom) return;
         len = bit_len;
         append_byte(PAD_MARK);
         while (fill != LEN_POS) append_byte(PAD_ZERO);
         for (int i = 0; i < LEN_BYTES; i++) append_byte(len[LEN_W-1-8*i -: 8]);
         for (int i = 0; i <= LAST_INDEX; i++) begin
            entry.digest_word = chain[i];
            entry.word_index  = i[INDEX_W-1:0];
            entry.last_word   = (i == LAST_INDEX);
            expected_digest_words.push_back(entry);
         end
         restart();
      endfunction

      function void note_error();
         errors++;
      endfunction

      // Compares one accepted digest word against the oldest one due.
      function void check_digest_word(word_type word, logic [INDEX_W-1:0] index,
                                      logic last);
         digest_entry_type exp_entry;
         if (expected_digest_words.size() == 0) begin
            if (errors < MAX_REPORTS)
               $display("%0t: unexpected digest word %h index %0d last %0b",
                        $time, word, index, last);
            note_error();
            return;
         end
         exp_entry = expected_digest_words.pop_front();
         if (word !== exp_entry.digest_word || index !== exp_entry.word_index ||
             last !== exp_entry.last_word) begin
            if (errors < MAX_REPORTS)
               $display("%0t: digest mismatch: expected %h/%0d/%0b, actual %h/%0d/%0b",
                        $time, exp_entry.digest_word, exp_entry.word_index,
                        exp_entry.last_word, word, index, last);
            note_error();
         end
      endfunction

      function int unsigned pending();
         return expected_digest_words.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   sha1md_req_if req_bus ();
   sha1md_rsp_if rsp_bus ();

   sha1_message_digest dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   sha1_digest_scoreboard scoreboard = new();

   bit          sender_steady;
   bit          receiver_steady;
   int unsigned items_sent;
   int unsigned words_taken;
   int unsigned cycle_count;

   // Clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** sha1_message_digest: FAILED **");
         $finish;
      end
   end

   // Monitors: every accepted word goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready)
         scoreboard.absorb_word(req_bus.data_byte, req_bus.byte_present,
                                req_bus.end_of_message);
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         scoreboard.check_digest_word(rsp_bus.digest_word, rsp_bus.word_index,
                                      rsp_bus.last_word);
   end

   // Offers one input word, after a random gap unless the sender is steady, and waits until it is taken.
   task automatic send_item(input logic [BYTE_W-1:0] data, input logic present,
                            input logic eom);
      int unsigned gap;
      gap = sender_steady ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.data_byte      <= data;
      req_bus.byte_present   <= present;
      req_bus.end_of_message <= eom;
      do @(posedge clock); while (!req_bus.ready);
      if (present || eom) items_sent++;
   endtask

   // A message of random bytes, closed either on its last byte or by a bare end.
   // Now and then a word with neither byte nor end is slipped in.
   task automatic send_message(input int unsigned len, input bit bare_end);
      sender_steady = ($urandom_range(0, 3) == 0);
      for (int unsigned i = 0; i < len; i++) begin
         if ($urandom_range(0, 15) == 0)
            send_item(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b0);
         send_item(BYTE_W'($urandom_range(0, 255)), 1'b1, !bare_end && (i == len - 1));
      end
      if (bare_end || len == 0) send_item(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   // Receiver: random hold-off before each digest word, with one long stall.
   initial begin
      int unsigned hold;
      rsp_bus.ready   = 1'b0;
      receiver_steady = 1'b0;
      words_taken     = 0;
      do @(posedge clock); while (reset);
      forever begin
         if (words_taken % 5 == 0) receiver_steady = ($urandom_range(0, 3) == 0);
         if (words_taken == HOLD_AT_WORD)
            hold = LONG_HOLD;
         else
            hold = receiver_steady ? 0 : $urandom_range(0, MAX_IDLE);
         if (hold != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         words_taken++;
      end
   end

   // Reset, directed words, random messages, then drain and verdict.
   initial begin
      int unsigned len;
      int unsigned edge_lens[9];
      edge_lens              = '{54, 55, 56, 57, 63, 64, 65, 119, 120};
      reset                  = 1'b1;
      req_bus.valid          = 1'b0;
      req_bus.data_byte      = '0;
      req_bus.byte_present   = 1'b0;
      req_bus.end_of_message = 1'b0;
      sender_steady          = 1'b0;
      items_sent             = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // A word with neither byte nor end must be ignored.
      send_item(8'hff, 1'b0, 1'b0);
      // Empty message.
      send_item(8'h00, 1'b0, 1'b1);
      // "abc", closed on its last byte.
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b1);
      // Single bytes at the extremes, closed with and without a byte.
      send_item(8'hff, 1'b1, 1'b1);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b0);
      send_item(8'hff, 1'b0, 1'b1);
      // Back-to-back empty messages.
      sender_steady = 1'b1;
      send_item(8'hff, 1'b0, 1'b1);
      send_item(8'h00, 1'b0, 1'b1);

      // Random messages: mostly short, some on the padding and block boundaries.
      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 3))
            0, 1: begin
               len = $urandom_range(0, 20);
            end
            2: begin
               len = edge_lens[$urandom_range(0, 8)];
            end
            default: begin
               len = $urandom_range(0, 130);
            end
         endcase
         send_message(len, 1'($urandom_range(0, 1)));
      end
      req_bus.valid <= 1'b0;

      // Let the monitor note the last accepted word before looking at the queue.
      @(posedge clock);
      while (scoreboard.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (scoreboard.errors == 0)
         $display("** sha1_message_digest: PASSED **");
      else
         $display("** sha1_message_digest: FAILED **");
      $finish;
   end

endmodule
